>>> rtl/core/lvm_pkg.sv
package lvm_pkg;

	localparam int Q_W    = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = 2 * Q_W;
	localparam int WIDE_W = PROD_W + 2;
	localparam int EPS_W  = 17;
	localparam int QUO_W  = FRAC_W + 1;

	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	typedef logic [Q_W-1:0] q16_t;
	typedef logic [2:0][Q_W-1:0] vec3_t;
	typedef logic [EPS_W-1:0] eps_t;

	typedef struct packed {
		q16_t eye_x;
		q16_t eye_y;
		q16_t eye_z;
		q16_t target_x;
		q16_t target_y;
		q16_t target_z;
		q16_t up_hint_x;
		q16_t up_hint_y;
		q16_t up_hint_z;
	} lvm_req_t;

	typedef struct packed {
		q16_t fwd_x;
		q16_t fwd_y;
		q16_t fwd_z;
		q16_t right_x;
		q16_t right_y;
		q16_t right_z;
		q16_t new_up_x;
		q16_t new_up_y;
		q16_t new_up_z;
		q16_t trans_fwd;
		q16_t trans_right;
		q16_t trans_up;
	} lvm_rsp_t;

	function automatic logic signed [PROD_W-1:0] smul(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		return a * b;
	endfunction

	function automatic q16_t sat32(input logic signed [WIDE_W-1:0] x);
		logic [WIDE_W-Q_W:0] hi;
		hi = x[WIDE_W-1:Q_W-1];
		if (hi == '0 || hi == '1) begin
			return x[Q_W-1:0];
		end
		return x[WIDE_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
	endfunction

	// (a - b) floored by 2^16, saturated
	function automatic q16_t xterm(input logic signed [PROD_W-1:0] a,
		input logic signed [PROD_W-1:0] b);
		logic signed [PROD_W:0] d;
		d = (PROD_W+1)'(a) - (PROD_W+1)'(b);
		return sat32(WIDE_W'(d >>> FRAC_W));
	endfunction

	// minus the sum of three floored products, saturated
	function automatic q16_t ndot(input logic signed [PROD_W-1:0] p0,
		input logic signed [PROD_W-1:0] p1, input logic signed [PROD_W-1:0] p2);
		logic signed [WIDE_W-1:0] s;
		s = WIDE_W'(p0 >>> FRAC_W) + WIDE_W'(p1 >>> FRAC_W) + WIDE_W'(p2 >>> FRAC_W);
		return sat32(-s);
	endfunction

endpackage

>>> rtl/core/lvm_stream_if.sv
interface lvm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/lvm_norm.sv
module lvm_norm
	import lvm_pkg::*;
#(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  eps_t              eps,
	input  logic              in_vld,
	input  vec3_t             in_vec,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output vec3_t             out_vec,
	output logic [SIDE_W-1:0] out_side
);
	localparam int SQ_W   = PROD_W - 1;
	localparam int ROOT_W = Q_W;
	localparam int REM_W  = ROOT_W + 3;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
		logic [PROD_W-1:0] rad;
		vec3_t             vec;
		logic [SIDE_W-1:0] side;
	} root_st_t;

	typedef struct packed {
		logic [ROOT_W-1:0]           den;
		logic                        norm;
		logic [2:0]                  neg;
		logic [2:0][ROOT_W-1:0]      rem;
		logic [2:0][QUO_W-1:0]       quo;
		vec3_t                       vec;
		logic [SIDE_W-1:0]           side;
	} div_st_t;

	// squares and their sum
	logic                 vld_s1, vld_s2;
	vec3_t                vec_s1, vec_s2;
	logic [SIDE_W-1:0]    side_s1, side_s2;
	logic [2:0][SQ_W-1:0] sq_s1;
	logic [PROD_W-1:0]    sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1  <= in_vec;
			side_s1 <= in_side;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= SQ_W'(smul(in_vec[i], in_vec[i]));
			end
			vec_s2  <= vec_s1;
			side_s2 <= side_s1;
			sum_s2  <= PROD_W'(sq_s1[0]) + PROD_W'(sq_s1[1]) + PROD_W'(sq_s1[2]);
		end
	end

	// square root, one result bit per stage
	root_st_t rt_q   [ROOT_W];
	logic     rt_vld [ROOT_W];

	for (genvar t = 0; t < ROOT_W; t++) begin : g_root
		root_st_t         src;
		root_st_t         nxt;
		logic             src_vld;
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (t == 0) begin : g_first
			always_comb begin
				src      = '0;
				src.rad  = sum_s2;
				src.vec  = vec_s2;
				src.side = side_s2;
				src_vld  = vld_s2;
			end
		end else begin : g_next
			assign src     = rt_q[t-1];
			assign src_vld = rt_vld[t-1];
		end

		always_comb begin
			rem_sh   = {src.rem[REM_W-3:0], src.rad[PROD_W-1 -: 2]};
			trial    = {1'b0, src.root, 2'b01};
			ge       = rem_sh >= trial;
			nxt      = src;
			nxt.rem  = ge ? rem_sh - trial : rem_sh;
			nxt.root = {src.root[ROOT_W-2:0], ge};
			nxt.rad  = src.rad << 2;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld[t] <= 1'b0;
			end else if (en) begin
				rt_vld[t] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_q[t] <= nxt;
			end
		end
	end

	// threshold compare, magnitudes for the divider
	root_st_t   rt_last;
	div_st_t    cmp_s1;
	logic       cmp_vld_s1;
	logic [2:0] cmp_lsb_s1;

	assign rt_last = rt_q[ROOT_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_vld_s1 <= 1'b0;
		end else if (en) begin
			cmp_vld_s1 <= rt_vld[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [ROOT_W-1:0] mag;
		if (en) begin
			cmp_s1.den  <= rt_last.root;
			cmp_s1.norm <= rt_last.root > ROOT_W'(eps);
			cmp_s1.vec  <= rt_last.vec;
			cmp_s1.side <= rt_last.side;
			for (int i = 0; i < 3; i++) begin
				mag = rt_last.vec[i][Q_W-1] ? -rt_last.vec[i] : rt_last.vec[i];
				cmp_s1.neg[i] <= rt_last.vec[i][Q_W-1];
				cmp_s1.rem[i] <= {1'b0, mag[ROOT_W-1:1]};
				cmp_s1.quo[i] <= '0;
				cmp_lsb_s1[i] <= mag[0];
			end
		end
	end

	// restoring division of |v| * 2^16 by the length, one quotient bit per stage
	div_st_t dv_q   [QUO_W];
	logic    dv_vld [QUO_W];

	for (genvar t = 0; t < QUO_W; t++) begin : g_div
		div_st_t    src;
		div_st_t    nxt;
		logic       src_vld;
		logic [2:0] bit_in;

		if (t == 0) begin : g_first
			assign src     = cmp_s1;
			assign src_vld = cmp_vld_s1;
			assign bit_in  = cmp_lsb_s1;
		end else begin : g_next
			assign src     = dv_q[t-1];
			assign src_vld = dv_vld[t-1];
			assign bit_in  = '0;
		end

		always_comb begin
			nxt = src;
			for (int i = 0; i < 3; i++) begin
				logic [ROOT_W:0] rsh;
				logic            ge;
				rsh = {src.rem[i], bit_in[i]};
				ge  = rsh >= {1'b0, src.den};
				nxt.rem[i] = ge ? ROOT_W'(rsh - {1'b0, src.den}) : rsh[ROOT_W-1:0];
				nxt.quo[i] = {src.quo[i][QUO_W-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[t] <= 1'b0;
			end else if (en) begin
				dv_vld[t] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_q[t] <= nxt;
			end
		end
	end

	// pick quotient or pass the vector through
	div_st_t           dv_last;
	logic              sel_vld_q;
	vec3_t             sel_vec_q;
	logic [SIDE_W-1:0] sel_side_q;

	assign dv_last = dv_q[QUO_W-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_vld_q <= 1'b0;
		end else if (en) begin
			sel_vld_q <= dv_vld[QUO_W-1];
		end
	end

	always_ff @(posedge clk) begin
		q16_t qx;
		if (en) begin
			sel_side_q <= dv_last.side;
			for (int i = 0; i < 3; i++) begin
				qx = Q_W'(dv_last.quo[i]);
				if (dv_last.norm) begin
					sel_vec_q[i] <= dv_last.neg[i] ? -qx : qx;
				end else begin
					sel_vec_q[i] <= dv_last.vec[i];
				end
			end
		end
	end

	assign out_vld  = sel_vld_q;
	assign out_vec  = sel_vec_q;
	assign out_side = sel_side_q;

endmodule

>>> rtl/core/look_at_view_matrix.sv
// Look-at view matrix builder, signed Q16.16 throughout.
// req (sink) takes one item: eye point, target point and up hint.
// rsp (source) returns one item per request: forward, right and new up
// axes plus the three translations -dot(axis, eye), all saturated.
// cfg (sink) writes length_epsilon; it is always ready and should only be
// written while no item is in flight.
// Throughput: one item per cycle while req.ready is high. An item passes
// through the two normalizers (each: squares, 32-stage square root,
// threshold, 17-stage divider, select) plus the cross and dot product
// stages.
// A two-entry output buffer sits after the pipeline: the pipeline keeps
// advancing while the receiver stalls until that buffer is full, then the
// whole pipeline holds and req.ready drops; no item is lost or repeated.
// Reset empties the pipeline and buffer and sets length_epsilon to 1.
module look_at_view_matrix
	import lvm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lvm_stream_if.sink   req,
	lvm_stream_if.source rsp,
	lvm_stream_if.sink   cfg
);
	localparam logic [1:0] BUF_EMPTY = 2'd0;
	localparam logic [1:0] BUF_ONE   = 2'd1;
	localparam logic [1:0] BUF_FULL  = 2'd2;

	typedef struct packed {
		vec3_t eye;
		vec3_t up;
	} n1_side_t;

	typedef struct packed {
		vec3_t fwd;
		vec3_t eye;
	} n2_side_t;

	logic       en;
	logic [1:0] cnt_q;
	eps_t       eps_q;
	logic       push, pop;

	assign en        = cnt_q != BUF_FULL;
	assign req.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg.valid) begin
			eps_q <= EPS_W'(cfg.data);
		end
	end

	// input unpack
	vec3_t in_eye, in_tgt, in_up;
	lvm_req_t rq;

	always_comb begin
		rq = req.data;
		in_eye[0] = rq.eye_x;
		in_eye[1] = rq.eye_y;
		in_eye[2] = rq.eye_z;
		in_tgt[0] = rq.target_x;
		in_tgt[1] = rq.target_y;
		in_tgt[2] = rq.target_z;
		in_up[0]  = rq.up_hint_x;
		in_up[1]  = rq.up_hint_y;
		in_up[2]  = rq.up_hint_z;
	end

	// stage 1: direction = target - eye
	logic  vld_s1;
	vec3_t dir_s1, eye_s1, up_s1;

	// normalizer outputs
	logic     n1_vld, n2_vld;
	vec3_t    n1_vec, n2_vec;
	n1_side_t n1_side;
	n2_side_t n2_side;

	// cross up x fwd
	logic              vld_s2, vld_s3;
	logic signed [PROD_W-1:0] xa_s2 [3];
	logic signed [PROD_W-1:0] xb_s2 [3];
	vec3_t             fwd_s2, eye_s2, fwd_s3, eye_s3, rgt_s3;

	// cross fwd x right, dots
	logic              vld_s4, vld_s5, vld_s6, vld_s7;
	logic signed [PROD_W-1:0] ua_s4 [3];
	logic signed [PROD_W-1:0] ub_s4 [3];
	logic signed [PROD_W-1:0] df_s4 [3];
	logic signed [PROD_W-1:0] dr_s4 [3];
	vec3_t             fwd_s4, rgt_s4, eye_s4;
	vec3_t             nup_s5, fwd_s5, rgt_s5, eye_s5;
	q16_t              tf_s5, tr_s5, tf_s6, tr_s6;
	logic signed [PROD_W-1:0] du_s6 [3];
	vec3_t             nup_s6, fwd_s6, rgt_s6;
	lvm_rsp_t          res_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld_s2 <= n1_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= n2_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dir_s1[i] <= sat32(WIDE_W'($signed(in_tgt[i])) - WIDE_W'($signed(in_eye[i])));
			end
			eye_s1 <= in_eye;
			up_s1  <= in_up;
		end
	end

	lvm_norm #(
		.SIDE_W ($bits(n1_side_t))
	) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.eps      (eps_q),
		.in_vld   (vld_s1),
		.in_vec   (dir_s1),
		.in_side  ({eye_s1, up_s1}),
		.out_vld  (n1_vld),
		.out_vec  (n1_vec),
		.out_side (n1_side)
	);

	// right = up x fwd; component i uses axes a = i+1, b = i+2 (mod 3)
	for (genvar i = 0; i < 3; i++) begin : g_cross1
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				xa_s2[i]  <= smul(n1_side.up[A], n1_vec[B]);
				xb_s2[i]  <= smul(n1_side.up[B], n1_vec[A]);
				rgt_s3[i] <= xterm(xa_s2[i], xb_s2[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s2 <= n1_vec;
			eye_s2 <= n1_side.eye;
			fwd_s3 <= fwd_s2;
			eye_s3 <= eye_s2;
		end
	end

	lvm_norm #(
		.SIDE_W ($bits(n2_side_t))
	) u_norm_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.eps      (eps_q),
		.in_vld   (vld_s3),
		.in_vec   (rgt_s3),
		.in_side  ({fwd_s3, eye_s3}),
		.out_vld  (n2_vld),
		.out_vec  (n2_vec),
		.out_side (n2_side)
	);

	// new up = fwd x right, and the eye dot products
	for (genvar i = 0; i < 3; i++) begin : g_cross2
		localparam int A = (i + 1) % 3;
		localparam int B = (i + 2) % 3;
		always_ff @(posedge clk) begin
			if (en) begin
				ua_s4[i]  <= smul(n2_side.fwd[A], n2_vec[B]);
				ub_s4[i]  <= smul(n2_side.fwd[B], n2_vec[A]);
				df_s4[i]  <= smul(n2_side.fwd[i], n2_side.eye[i]);
				dr_s4[i]  <= smul(n2_vec[i], n2_side.eye[i]);
				nup_s5[i] <= xterm(ua_s4[i], ub_s4[i]);
				du_s6[i]  <= smul(nup_s5[i], eye_s5[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_s4 <= n2_side.fwd;
			rgt_s4 <= n2_vec;
			eye_s4 <= n2_side.eye;

			fwd_s5 <= fwd_s4;
			rgt_s5 <= rgt_s4;
			eye_s5 <= eye_s4;
			tf_s5  <= ndot(df_s4[0], df_s4[1], df_s4[2]);
			tr_s5  <= ndot(dr_s4[0], dr_s4[1], dr_s4[2]);

			nup_s6 <= nup_s5;
			fwd_s6 <= fwd_s5;
			rgt_s6 <= rgt_s5;
			tf_s6  <= tf_s5;
			tr_s6  <= tr_s5;

			res_s7.fwd_x       <= fwd_s6[0];
			res_s7.fwd_y       <= fwd_s6[1];
			res_s7.fwd_z       <= fwd_s6[2];
			res_s7.right_x     <= rgt_s6[0];
			res_s7.right_y     <= rgt_s6[1];
			res_s7.right_z     <= rgt_s6[2];
			res_s7.new_up_x    <= nup_s6[0];
			res_s7.new_up_y    <= nup_s6[1];
			res_s7.new_up_z    <= nup_s6[2];
			res_s7.trans_fwd   <= tf_s6;
			res_s7.trans_right <= tr_s6;
			res_s7.trans_up    <= ndot(du_s6[0], du_s6[1], du_s6[2]);
		end
	end

	// two-entry output buffer
	lvm_rsp_t buf_head_q, buf_spare_q;

	assign push      = vld_s7 && en;
	assign pop       = rsp.valid && rsp.ready;
	assign rsp.valid = cnt_q != BUF_EMPTY;
	assign rsp.data  = buf_head_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= BUF_EMPTY;
		end else begin
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		case (cnt_q)
			BUF_EMPTY: begin
				if (push) begin
					buf_head_q <= res_s7;
				end
			end
			BUF_ONE: begin
				if (push && pop) begin
					buf_head_q <= res_s7;
				end else if (push) begin
					buf_spare_q <= res_s7;
				end
			end
			BUF_FULL: begin
				if (pop) begin
					buf_head_q <= buf_spare_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == BUF_FULL) |-> !req.ready)
		else $error("request accepted while output buffer full");

	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("output buffer count lost an item");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == BUF_EMPTY || cnt_q == BUF_ONE || cnt_q == BUF_FULL)
		else $error("output buffer count out of range");
`endif

endmodule
